// ----- hw/rtl/sesel_pkg.sv -----
// Package: shared types and constants of the schedule entry selector.
package sesel_pkg;

	localparam int unsigned KindWidth     = 1;
	localparam int unsigned IndexWidth    = 6;
	localparam int unsigned TimeWidth     = 32;
	localparam int unsigned DurWidth      = 16;
	localparam int unsigned PrioReqWidth  = 8;
	localparam int unsigned CountWidth    = 7;
	localparam int unsigned SecPerMinute  = 60;
	// Widest duration in seconds: 16-bit minutes times 60 fits in 22 bits.
	localparam int unsigned DurSecWidth   = 22;
	localparam int unsigned EndWidth      = TimeWidth + 1;

	localparam logic [KindWidth-1:0] KIND_LOAD   = 1'b0;
	localparam logic [KindWidth-1:0] KIND_SELECT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic load_we;
		logic scan_start;
		logic scan_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic issue_done;
		logic pipe_busy;
		logic out_free;
	} sts_t;

endpackage

// ----- hw/rtl/sesel_in_if.sv -----
// Interface: input item channel.
interface sesel_in_if;
	logic                                   valid;
	logic                                   ready;
	logic [sesel_pkg::KindWidth-1:0]        kind;
	logic [sesel_pkg::IndexWidth-1:0]       entry_index;
	logic [sesel_pkg::TimeWidth-1:0]        start_time;
	logic [sesel_pkg::DurWidth-1:0]         window_min;
	logic [sesel_pkg::PrioReqWidth-1:0]     priority_req;
	logic [sesel_pkg::TimeWidth-1:0]        now_time;

	modport source (
		output valid, kind, entry_index, start_time, window_min, priority_req, now_time,
		input  ready
	);
	modport sink (
		input  valid, kind, entry_index, start_time, window_min, priority_req, now_time,
		output ready
	);
endinterface

// ----- hw/rtl/sesel_out_if.sv -----
// Interface: result item channel.
interface sesel_out_if;
	logic                             valid;
	logic                             ready;
	logic [sesel_pkg::IndexWidth-1:0] best_index;

	modport source (output valid, best_index, input ready);
	modport sink   (input valid, best_index, output ready);
endinterface

// ----- hw/rtl/schedule_entry_selector_top.sv -----
// Top level: schedule entry selector with entry table and priority scan.
// A load transfer writes its entry in the accept cycle and gives no result.
// A select reads N = min(entry_count, MAX_ENTRIES) entries through the read and compare stages,
// then waits in drain until the pipeline is empty and the previous result has been taken.
// No new item is accepted until a select has loaded its result; the scan reads one entry per cycle.
// Reset (arst_n low, asynchronous) clears entry_count and control state; table contents stay.
module schedule_entry_selector_top #(
	parameter int unsigned MAX_ENTRIES   = 64,
	parameter int unsigned PRIORITY_BITS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [sesel_pkg::CountWidth-1:0] cfg_wr_data,
	sesel_in_if.sink                         in_ch,
	sesel_out_if.source                      out_ch
);

	// Command and status between the controller and the datapath.
	// A new item is accepted while the previous result still waits in the output register.
	sesel_pkg::cmd_t cmd;
	sesel_pkg::sts_t sts;

	// Controller: owns input ready; decides load, scan and result hand-off.
	sesel_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_kind  (in_ch.kind),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: table memory, three-step compare pipeline and the output register.
	sesel_dp #(
		.MAX_ENTRIES   (MAX_ENTRIES),
		.PRIORITY_BITS (PRIORITY_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.entry_index  (in_ch.entry_index),
		.start_time   (in_ch.start_time),
		.window_min   (in_ch.window_min),
		.priority_req (in_ch.priority_req),
		.now_time     (in_ch.now_time),
		.out_valid    (out_ch.valid),
		.out_ready    (out_ch.ready),
		.best_index   (out_ch.best_index)
	);

endmodule

// ----- hw/rtl/sesel_ctrl.sv -----
// Controller: sequences entry loads, the table scan and result hand-off.
module sesel_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic [sesel_pkg::KindWidth-1:0] in_kind,
	output logic                            in_ready,
	input  sesel_pkg::sts_t                 sts,
	output sesel_pkg::cmd_t                 cmd
);

	sesel_pkg::state_t state_q;
	sesel_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sesel_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			sesel_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_kind == sesel_pkg::KIND_SELECT) begin
						cmd.scan_start = 1'b1;
						state_d        = sesel_pkg::ST_ISSUE;
					end else begin
						cmd.load_we = 1'b1;
					end
				end
			end
			sesel_pkg::ST_ISSUE: begin
				if (sts.issue_done) begin
					state_d = sesel_pkg::ST_DRAIN;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			sesel_pkg::ST_DRAIN: begin
				// Wait for the compare pipeline to empty and the output slot to free up.
				if (!sts.pipe_busy && sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = sesel_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sesel_pkg::ST_IDLE;
			end
		endcase
	end

	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_we |-> state_q == sesel_pkg::ST_IDLE)
		else $error("entry load outside idle");

	a_issue_to_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sesel_pkg::ST_ISSUE && sts.issue_done) |=> state_q == sesel_pkg::ST_DRAIN)
		else $error("scan did not move to drain");

	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (sts.out_free && !sts.pipe_busy))
		else $error("result loaded into busy output");

endmodule

// ----- hw/rtl/sesel_dp.sv -----
// Datapath: entry table memory, scan counter, scope/priority pipeline, output register.
module sesel_dp #(
	parameter int unsigned MAX_ENTRIES   = 64,
	parameter int unsigned PRIORITY_BITS = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sesel_pkg::cmd_t                    cmd,
	output sesel_pkg::sts_t                    sts,
	input  logic                               cfg_wr_en,
	input  logic [sesel_pkg::CountWidth-1:0]   cfg_wr_data,
	input  logic [sesel_pkg::IndexWidth-1:0]   entry_index,
	input  logic [sesel_pkg::TimeWidth-1:0]    start_time,
	input  logic [sesel_pkg::DurWidth-1:0]     window_min,
	input  logic [sesel_pkg::PrioReqWidth-1:0] priority_req,
	input  logic [sesel_pkg::TimeWidth-1:0]    now_time,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [sesel_pkg::IndexWidth-1:0]   best_index
);

	localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned MW = sesel_pkg::TimeWidth + sesel_pkg::DurWidth + PRIORITY_BITS;
	localparam int unsigned TW = sesel_pkg::TimeWidth;
	localparam int unsigned DW = sesel_pkg::DurWidth;
	localparam int unsigned CW = sesel_pkg::CountWidth;

	logic [MW-1:0] mem [MAX_ENTRIES];

	logic [CW-1:0]  entry_count_q;
	logic [CW-1:0]  count_sat;
	logic [CW-1:0]  cnt_q;
	logic [TW-1:0]  now_q;

	logic                     v_s1;
	logic [MW-1:0]            rd_s1;
	logic [AW-1:0]            idx_s1;

	logic                     v_s2;
	logic                     hit_s2;
	logic [PRIORITY_BITS-1:0] prio_s2;
	logic [AW-1:0]            idx_s2;

	logic [AW-1:0]            best_q;
	logic [PRIORITY_BITS-1:0] best_prio_q;
	logic                     out_valid_q;
	logic [sesel_pkg::IndexWidth-1:0] out_index_q;

	logic [TW-1:0]                      rd_start;
	logic [DW-1:0]                      rd_dur;
	logic [PRIORITY_BITS-1:0]           rd_prio;
	logic [sesel_pkg::DurSecWidth-1:0]  dur_sec;
	logic [sesel_pkg::EndWidth-1:0]     end_time;
	logic                               in_scope;

	always_comb begin
		if (32'(entry_count_q) > MAX_ENTRIES) begin
			count_sat = CW'(MAX_ENTRIES);
		end else begin
			count_sat = entry_count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_wr_en) begin
			entry_count_q <= cfg_wr_data;
		end
	end

	// Table write on load, registered read on scan step.
	always_ff @(posedge clk) begin
		if (cmd.load_we && (32'(entry_index) < MAX_ENTRIES)) begin
			mem[AW'(entry_index)] <= {start_time, window_min, PRIORITY_BITS'(priority_req)};
		end
		if (cmd.scan_step) begin
			rd_s1 <= mem[AW'(cnt_q)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
		end else begin
			v_s1 <= cmd.scan_step;
			v_s2 <= v_s1;
			if (cmd.scan_start) begin
				cnt_q <= '0;
			end else if (cmd.scan_step) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			now_q <= now_time;
		end
		if (cmd.scan_step) begin
			idx_s1 <= AW'(cnt_q);
		end
	end

	assign rd_start = rd_s1[MW-1 -: TW];
	assign rd_dur   = rd_s1[PRIORITY_BITS +: DW];
	assign rd_prio  = rd_s1[PRIORITY_BITS-1:0];
	// Minutes to seconds: times 64 minus times 4.
	assign dur_sec  = (sesel_pkg::DurSecWidth'(rd_dur) << 6)
		- (sesel_pkg::DurSecWidth'(rd_dur) << 2);
	assign end_time = sesel_pkg::EndWidth'(rd_start) + sesel_pkg::EndWidth'(dur_sec);
	assign in_scope = (now_q >= rd_start)
		&& ((rd_dur == '0) || (sesel_pkg::EndWidth'(now_q) <= end_time));

	always_ff @(posedge clk) begin
		hit_s2  <= in_scope;
		prio_s2 <= rd_prio;
		idx_s2  <= idx_s1;
		if (cmd.scan_start) begin
			best_q      <= '0;
			best_prio_q <= '0;
		end else if (v_s2 && hit_s2 && (prio_s2 >= best_prio_q)) begin
			best_q      <= idx_s2;
			best_prio_q <= prio_s2;
		end
		if (cmd.out_load) begin
			out_index_q <= sesel_pkg::IndexWidth'(best_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid      = out_valid_q;
	assign best_index     = out_index_q;
	assign sts.issue_done = (cnt_q == count_sat);
	assign sts.pipe_busy  = v_s1 || v_s2;
	assign sts.out_free   = !out_valid_q || out_ready;

	a_pipe_follows: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> $past(v_s1))
		else $error("compare stage valid without read stage");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step |-> (cnt_q < count_sat))
		else $error("scan stepped past entry count");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(out_index_q)))
		else $error("waiting result changed before transfer");

endmodule

// ----- bench/schedule_entry_selector_top_tb.sv -----
// Testbench: predicted best entries checked against output transfers.
module schedule_entry_selector_top_tb;

	localparam int unsigned MaxEntries   = 64;
	localparam int unsigned PrioBits     = 8;
	// Let a select finish; allow the widest scan plus margin before a write.
	localparam int unsigned SettleCycles = MaxEntries + 8;
	localparam int unsigned DrainLimit   = 50000;
	localparam int unsigned HoldOff      = 300;
	localparam logic [sesel_pkg::TimeWidth-1:0] BaseTime = 32'h6000_0000;

	typedef struct packed {
		logic [sesel_pkg::KindWidth-1:0]    kind;
		logic [sesel_pkg::IndexWidth-1:0]   entry_index;
		logic [sesel_pkg::TimeWidth-1:0]    start_time;
		logic [sesel_pkg::DurWidth-1:0]     window_min;
		logic [sesel_pkg::PrioReqWidth-1:0] priority_req;
		logic [sesel_pkg::TimeWidth-1:0]    now_time;
	} sched_item_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                             cfg_wr_en   = 1'b0;
	logic [sesel_pkg::CountWidth-1:0] cfg_wr_data = '0;

	// Local copies of what drives each channel; known from time zero.
	logic        in_valid  = 1'b0;
	sched_item_t in_item   = '0;
	logic        out_ready = 1'b0;

	sesel_in_if  in_ch ();
	sesel_out_if out_ch ();

	assign in_ch.valid        = in_valid;
	assign in_ch.kind         = in_item.kind;
	assign in_ch.entry_index  = in_item.entry_index;
	assign in_ch.start_time   = in_item.start_time;
	assign in_ch.window_min   = in_item.window_min;
	assign in_ch.priority_req = in_item.priority_req;
	assign in_ch.now_time     = in_item.now_time;
	assign out_ch.ready       = out_ready;

	schedule_entry_selector_top #(
		.MAX_ENTRIES   (MaxEntries),
		.PRIORITY_BITS (PrioBits)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_ch       (in_ch),
		.out_ch      (out_ch)
	);

	initial forever #4 clk = ~clk;

	// Run limit: far above the slowest legal run of this item count.
	initial begin
		#8_000_000;
		$display("schedule_entry_selector_top regression: fail");
		$finish;
	end

	// ---------------------------------------------------------------
	// Predictor state: mirror of the entry table and the scan length,
	// updated at the cycle of each accepted input transfer.
	// ---------------------------------------------------------------
	logic [sesel_pkg::TimeWidth-1:0]    tbl_start [MaxEntries];
	logic [sesel_pkg::DurWidth-1:0]     tbl_dur   [MaxEntries];
	logic [sesel_pkg::PrioReqWidth-1:0] tbl_prio  [MaxEntries];
	logic [sesel_pkg::CountWidth-1:0]   pred_count = '0;

	logic [sesel_pkg::IndexWidth-1:0] expected_best [$];
	sched_item_t                      pending_items [$];

	int unsigned err_count     = 0;
	int unsigned missing_count = 0;

	// Pacing knobs, set by the stimulus process; the monitor keeps the stall counters.
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned stall_ticket  = 0;
	int unsigned stall_taken   = 0;
	int unsigned stall_left    = 0;

	// Scan entries 0..N-1; the in-scope entry with the highest priority wins,
	// the later index wins a tie, and 0 comes back when nothing is in scope.
	function automatic logic [sesel_pkg::IndexWidth-1:0] pick_best_entry(
			logic [sesel_pkg::TimeWidth-1:0] now);
		int unsigned                        span;
		int unsigned                        c;
		logic [sesel_pkg::IndexWidth-1:0]   best;
		logic [sesel_pkg::PrioReqWidth-1:0] best_prio;
		logic [sesel_pkg::EndWidth-1:0]     stop;
		span      = (pred_count > MaxEntries) ? MaxEntries : pred_count;
		best      = '0;
		best_prio = '0;
		for (c = 0; c < span; c++) begin
			// End time is formed one bit wider than a time, so it never wraps.
			stop = sesel_pkg::EndWidth'(tbl_start[c])
				+ sesel_pkg::EndWidth'(tbl_dur[c]) * sesel_pkg::EndWidth'(sesel_pkg::SecPerMinute);
			if (now >= tbl_start[c] && (tbl_dur[c] == '0 || stop >= sesel_pkg::EndWidth'(now))
					&& tbl_prio[c] >= best_prio) begin
				best_prio = tbl_prio[c];
				best      = sesel_pkg::IndexWidth'(c);
			end
		end
		return best;
	endfunction

	// Apply one accepted transfer: a load updates the table, a select
	// queues its predicted answer.
	task automatic record_transfer(input sched_item_t item);
		if (item.kind == sesel_pkg::KIND_LOAD) begin
			tbl_start[item.entry_index] = item.start_time;
			tbl_dur[item.entry_index]   = item.window_min;
			tbl_prio[item.entry_index]  = item.priority_req;
		end else begin
			expected_best.push_back(pick_best_entry(item.now_time));
		end
	endtask

	// ---------------------------------------------------------------
	// Driver: hold valid and payload until the transfer, then advance to
	// the next pending item or idle at random.
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (in_valid && in_ch.ready)
			record_transfer(in_item);
		if (!in_valid || in_ch.ready) begin
			if (arst_n && pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				in_item  <= pending_items.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Monitor: compare every result transfer with the oldest prediction,
	// then choose ready for the next cycle. A new stall ticket starts a
	// long hold-off counted here.
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (out_ready && out_ch.valid) begin
			if (expected_best.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual best_index %0d",
					$time, out_ch.best_index);
				err_count++;
			end else if (out_ch.best_index !== expected_best[0]) begin
				$display("%0t: best_index mismatch: expected %0d, actual %0d",
					$time, expected_best[0], out_ch.best_index);
				err_count++;
				void'(expected_best.pop_front());
			end else begin
				void'(expected_best.pop_front());
			end
		end
		if (stall_ticket != stall_taken) begin
			stall_taken <= stall_ticket;
			stall_left  <= HoldOff;
			out_ready   <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else begin
			out_ready <= arst_n && ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// ---------------------------------------------------------------
	// Stimulus planning. The planner keeps its own view of the table so
	// that selects aim at entry boundaries and never scan an unwritten slot.
	// ---------------------------------------------------------------
	logic [MaxEntries-1:0]              gen_written = '0;
	logic [sesel_pkg::TimeWidth-1:0]    gen_start [MaxEntries];
	logic [sesel_pkg::DurWidth-1:0]     gen_dur   [MaxEntries];

	function automatic sched_item_t plan_load(logic [sesel_pkg::IndexWidth-1:0] slot,
			logic [sesel_pkg::TimeWidth-1:0] st, logic [sesel_pkg::DurWidth-1:0] dur,
			logic [sesel_pkg::PrioReqWidth-1:0] prio);
		sched_item_t item;
		item.kind         = sesel_pkg::KIND_LOAD;
		item.entry_index  = slot;
		item.start_time   = st;
		item.window_min   = dur;
		item.priority_req = prio;
		item.now_time     = $urandom;
		gen_written[slot] = 1'b1;
		gen_start[slot]   = st;
		gen_dur[slot]     = dur;
		return item;
	endfunction

	// Unused load fields get random values as well.
	function automatic sched_item_t plan_select(logic [sesel_pkg::TimeWidth-1:0] now);
		sched_item_t item;
		item.kind         = sesel_pkg::KIND_SELECT;
		item.entry_index  = sesel_pkg::IndexWidth'($urandom);
		item.start_time   = $urandom;
		item.window_min   = sesel_pkg::DurWidth'($urandom);
		item.priority_req = sesel_pkg::PrioReqWidth'($urandom);
		item.now_time     = now;
		return item;
	endfunction

	function automatic sched_item_t random_load(logic [sesel_pkg::IndexWidth-1:0] slot);
		logic [sesel_pkg::TimeWidth-1:0]    st;
		logic [sesel_pkg::DurWidth-1:0]     dur;
		logic [sesel_pkg::PrioReqWidth-1:0] prio;
		// Cluster part of the starts so entries overlap; keep some at the extremes.
		case ($urandom_range(0, 9))
			0, 1, 2, 3: st = BaseTime + $urandom_range(0, 20000);
			4, 5, 6, 7: st = $urandom;
			8:          st = '0;
			default:    st = '1 - $urandom_range(0, 5000000);
		endcase
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4:       dur = '0;
			5, 6, 7, 8, 9, 10, 11, 12: dur = sesel_pkg::DurWidth'($urandom_range(1, 300));
			13, 14, 15, 16, 17:  dur = sesel_pkg::DurWidth'($urandom);
			default:             dur = '1;
		endcase
		// Small priorities make ties frequent.
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: prio = sesel_pkg::PrioReqWidth'($urandom_range(0, 3));
			5, 6, 7, 8:    prio = sesel_pkg::PrioReqWidth'($urandom);
			default:       prio = $urandom_range(0, 1) ? '1 : '0;
		endcase
		return plan_load(slot, st, dur, prio);
	endfunction

	function automatic sched_item_t random_item(int unsigned count);
		int unsigned                     span;
		int unsigned                     c;
		int unsigned                     hole;
		logic [sesel_pkg::TimeWidth-1:0] st;
		logic [sesel_pkg::TimeWidth-1:0] stop;
		span = (count > MaxEntries) ? MaxEntries : count;
		hole = span;
		for (c = 0; c < span; c++)
			if (!gen_written[c] && hole == span)
				hole = c;
		// Fill the scanned range before any select may look at it.
		if (hole < span)
			return random_load(sesel_pkg::IndexWidth'(hole));
		if ($urandom_range(0, 99) < 30)
			return random_load(sesel_pkg::IndexWidth'($urandom_range(0, MaxEntries - 1)));
		if (span == 0)
			return plan_select($urandom);
		c  = $urandom_range(0, span - 1);
		st = gen_start[c];
		if (gen_dur[c] == '0)
			stop = st + $urandom_range(0, 1000);
		else
			stop = st + sesel_pkg::TimeWidth'(gen_dur[c])
				* sesel_pkg::TimeWidth'(sesel_pkg::SecPerMinute);
		// Aim at the edges of one entry's window; some plain noise too.
		case ($urandom_range(0, 7))
			0:       return plan_select(st - 1);
			1:       return plan_select(st);
			2:       return plan_select(stop);
			3:       return plan_select(stop + 1);
			4:       return plan_select(st + $urandom_range(0, 3000));
			5:       return plan_select($urandom);
			6:       return plan_select('0);
			default: return plan_select('1);
		endcase
	endfunction

	// Wait until the driver is empty and every predicted result has come,
	// then optionally let the widest scan settle before touching the register.
	task automatic drain_results(input bit settle);
		int unsigned waited;
		waited = 0;
		while ((pending_items.size() != 0 || in_valid || expected_best.size() != 0)
				&& waited < DrainLimit) begin
			@(posedge clk);
			waited++;
		end
		if (expected_best.size() != 0) begin
			$display("%0t: results missing: expected %0d more, actual none",
				$time, expected_best.size());
			missing_count += expected_best.size();
		end
		if (settle)
			repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_entry_count(input logic [sesel_pkg::CountWidth-1:0] value);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		pred_count  = value;
	endtask

	// One idle-to-idle phase: register write, pacing, then random items.
	task automatic run_phase(input logic [sesel_pkg::CountWidth-1:0] count,
			input int unsigned send_pct, input int unsigned recv_pct,
			input int unsigned n_items, input bit mid_pause, input bit long_hold);
		int unsigned k;
		drain_results(1'b1);
		write_entry_count(count);
		send_idle_pct <= send_pct;
		recv_idle_pct <= recv_pct;
		if (long_hold)
			stall_ticket <= stall_ticket + 1;
		for (k = 0; k < n_items; k++) begin
			// Hold the sender back until every outstanding result is in.
			if (mid_pause && k == n_items / 2)
				drain_results(1'b0);
			pending_items.push_back(random_item(count));
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty scan, extreme entries, window edges and ties.
		write_entry_count('0);
		send_idle_pct <= 38;
		recv_idle_pct <= 57;
		pending_items.push_back(plan_select('0));
		pending_items.push_back(plan_select('1));
		pending_items.push_back(plan_load(6'd0, 32'd1000, 16'd1, 8'd7));
		pending_items.push_back(plan_load(6'd1, 32'd1000, 16'd0, 8'd5));
		pending_items.push_back(plan_load(6'd2, 32'd1100, 16'd0, 8'd5));
		pending_items.push_back(plan_load(6'd3, 32'hFFFF_0000, '1, '1));
		pending_items.push_back(plan_load(6'd63, '1, '1, '1));
		drain_results(1'b1);
		write_entry_count(sesel_pkg::CountWidth'(4));
		pending_items.push_back(plan_select(32'd999));         // nothing in scope yet
		pending_items.push_back(plan_select(32'd1000));        // start is inclusive
		pending_items.push_back(plan_select(32'd1060));        // end is inclusive
		pending_items.push_back(plan_select(32'd1061));        // bounded entry expired
		pending_items.push_back(plan_select(32'd1100));        // equal priority, later wins
		pending_items.push_back(plan_select(32'hFFFE_FFFF));
		pending_items.push_back(plan_select(32'hFFFF_0000));
		pending_items.push_back(plan_select('1));              // end past the 32-bit range
		pending_items.push_back(plan_select('0));

		// Random phases: receiver sparse, then sender sparse, then no idling.
		run_phase(sesel_pkg::CountWidth'(64),  38, 57, 150, 1'b0, 1'b0);
		run_phase(sesel_pkg::CountWidth'(9),   38, 57, 150, 1'b0, 1'b0);
		run_phase('1,                          38, 57, 100, 1'b0, 1'b0);
		run_phase(sesel_pkg::CountWidth'(1),   57, 38, 100, 1'b0, 1'b0);
		run_phase(sesel_pkg::CountWidth'(64),  57, 38, 150, 1'b0, 1'b0);
		run_phase(sesel_pkg::CountWidth'(33),  57, 38, 100, 1'b1, 1'b0);
		run_phase('1,                          0,  0,  150, 1'b0, 1'b1);
		run_phase('0,                          0,  0,  50,  1'b0, 1'b0);
		run_phase(sesel_pkg::CountWidth'($urandom_range(2, 63)), 0, 0, 150, 1'b0, 1'b0);

		drain_results(1'b1);
		if (err_count == 0 && missing_count == 0) begin
			$display("schedule_entry_selector_top regression: pass");
		end else begin
			$display("schedule_entry_selector_top regression: fail");
		end
		$finish;
	end

endmodule
